// ===== rtl/core/prsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsc_pkg
// Shared widths, constants and register indexes of the printable rotation
// stream cipher.
// ----------------------------------------------------------------------------
package prsc_pkg;

    localparam int BYTE_W = 8;
    localparam int KS_W   = 17;
    localparam int PROD_W = 24;
    localparam int KEY_W  = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [6:0]      KS_MULT    = 7'd75;
    localparam logic [KS_W-1:0] KS_MODULUS = 17'd65537;
    localparam logic [KS_W-1:0] SEED_RESET = 17'd1;

    localparam logic [BYTE_W-1:0] PRINT_LO   = 8'd32;
    localparam logic [BYTE_W-1:0] PRINT_HI   = 8'd128;
    localparam logic [KEY_W:0]    PRINT_SPAN = 8'd96;

    localparam logic [CFG_IDX_W-1:0] REG_START_SEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 1'b1;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

endpackage

// ===== rtl/core/prsc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsc_in_if
// Input byte channel: valid/ready with data byte and stream start flag.
// ----------------------------------------------------------------------------
interface prsc_in_if;
    logic                          valid;
    logic                          ready;
    logic [prsc_pkg::BYTE_W-1:0]   data_byte;
    logic                          stream_start;

    modport source (output valid, output data_byte, output stream_start, input ready);
    modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

// ===== rtl/core/prsc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsc_out_if
// Result byte channel: valid/ready with the output byte.
// ----------------------------------------------------------------------------
interface prsc_out_if;
    logic                          valid;
    logic                          ready;
    logic [prsc_pkg::BYTE_W-1:0]   out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

// ===== rtl/core/prsc_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsc_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface prsc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [prsc_pkg::CFG_IDX_W-1:0]   index;
    logic [prsc_pkg::KS_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/prsc_keygen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsc_keygen
// Lehmer keystream register: value*75 mod 65537 per accepted word, with an
// optional reload from the seed before the step.
// ----------------------------------------------------------------------------
module prsc_keygen (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic                         i_start,
    input  logic [prsc_pkg::KS_W-1:0]    i_seed,
    output logic [prsc_pkg::KS_W-1:0]    o_value
);

    logic [prsc_pkg::KS_W-1:0]   r_value;
    logic [prsc_pkg::KS_W-1:0]   n_value;
    logic [prsc_pkg::KS_W-1:0]   base;
    logic [prsc_pkg::PROD_W-1:0] prod;
    logic [prsc_pkg::KS_W:0]     diff;

    always_comb begin
        base = i_start ? i_seed : r_value;
        prod = {{(prsc_pkg::PROD_W-prsc_pkg::KS_W){1'b0}}, base}
             * {{(prsc_pkg::PROD_W-7){1'b0}}, prsc_pkg::KS_MULT};
        // low half minus high half; wraps negative in 18 bits
        diff = {2'b00, prod[15:0]} - {10'd0, prod[23:16]};
        if (diff[prsc_pkg::KS_W]) begin
            n_value = diff[prsc_pkg::KS_W-1:0] + prsc_pkg::KS_MODULUS;
        end else begin
            n_value = diff[prsc_pkg::KS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= prsc_pkg::SEED_RESET;
        end else if (i_step) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

// ===== rtl/core/prsc_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prsc_rotate
// Rotates a printable byte (32..127) by keystream mod 96, forward or
// backward; other bytes pass unchanged.
// ----------------------------------------------------------------------------
module prsc_rotate (
    input  logic [prsc_pkg::BYTE_W-1:0]  i_byte,
    input  logic [prsc_pkg::KS_W-1:0]    i_key,
    input  logic                         i_dir,
    output logic [prsc_pkg::BYTE_W-1:0]  o_byte
);

    logic [4:0]                  dsum;
    logic [4:0]                  m_a;
    logic [4:0]                  m_b;
    logic [4:0]                  m_c;
    logic [prsc_pkg::KEY_W-1:0]  key;
    logic [prsc_pkg::KEY_W:0]    off;
    logic [prsc_pkg::KEY_W:0]    sum;
    logic [prsc_pkg::KEY_W:0]    wrapped;

    always_comb begin
        // key mod 96 = 32 * ((key >> 5) mod 3) + key[4:0]; base-4 digit sum for mod 3
        dsum = {3'd0, i_key[6:5]}   + {3'd0, i_key[8:7]}   + {3'd0, i_key[10:9]}
             + {3'd0, i_key[12:11]} + {3'd0, i_key[14:13]} + {3'd0, i_key[16:15]};
        m_a = (dsum >= 5'd9) ? dsum - 5'd9 : dsum;
        m_b = (m_a  >= 5'd6) ? m_a  - 5'd6 : m_a;
        m_c = (m_b  >= 5'd3) ? m_b  - 5'd3 : m_b;
        key = {m_c[1:0], i_key[4:0]};

        off = i_byte - prsc_pkg::PRINT_LO;
        if (i_dir == prsc_pkg::DIR_DECRYPT) begin
            sum = off + prsc_pkg::PRINT_SPAN - {1'b0, key};
        end else begin
            sum = off + {1'b0, key};
        end
        wrapped = (sum >= prsc_pkg::PRINT_SPAN) ? sum - prsc_pkg::PRINT_SPAN : sum;

        if (i_byte < prsc_pkg::PRINT_LO || i_byte >= prsc_pkg::PRINT_HI) begin
            o_byte = i_byte;
        end else begin
            o_byte = wrapped + prsc_pkg::PRINT_LO;
        end
    end

endmodule

// ===== rtl/core/printable_rotation_stream_cipher.sv =====
`timescale 1ns / 1ps
// Stages: the input/keystream stage, then the result stage.
// Throughput: one word per cycle while the output is not stalled; the keystream register steps once per accepted word.
// Input ready drops only when both the keystream stage and the result register are full.
// Reset (synchronous, active low): pipeline empty, keystream 1, seed 1, direction encrypt.
// Configuration writes are taken every cycle; write only while no word is in flight.
// ----------------------------------------------------------------------------
// printable_rotation_stream_cipher
// Byte stream cipher: Lehmer mod 65537 keystream, rotation within printable codes.
// ----------------------------------------------------------------------------
module printable_rotation_stream_cipher (
    input  logic             i_clk,
    input  logic             i_rst_n,
    prsc_in_if.sink          i_in,
    prsc_out_if.source       o_out,
    prsc_cfg_if.sink         i_cfg
);

    logic [prsc_pkg::KS_W-1:0]    r_seed;
    logic                         r_dir;
    logic                         r_v1;
    logic [prsc_pkg::BYTE_W-1:0]  r_b1;
    logic                         r_ov;
    logic [prsc_pkg::BYTE_W-1:0]  r_ob;
    logic [prsc_pkg::BYTE_W-1:0]  n_ob;
    logic [prsc_pkg::KS_W-1:0]    ks;
    logic                         adv_out;
    logic                         adv_1;
    logic                         accept;

    assign adv_out = !r_ov || o_out.ready;
    assign adv_1   = !r_v1 || adv_out;
    assign accept  = i_in.valid && adv_1;

    assign i_in.ready  = adv_1;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= prsc_pkg::SEED_RESET;
            r_dir  <= prsc_pkg::DIR_ENCRYPT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                prsc_pkg::REG_START_SEED: r_seed <= i_cfg.data;
                prsc_pkg::REG_DIRECTION:  r_dir  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    prsc_keygen u_keygen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (accept),
        .i_start (i_in.stream_start),
        .i_seed  (r_seed),
        .o_value (ks)
    );

    // keystream register holds this word's value until the word moves on
    prsc_rotate u_rotate (
        .i_byte (r_b1),
        .i_key  (ks),
        .i_dir  (r_dir),
        .o_byte (n_ob)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (adv_1) begin
                r_v1 <= i_in.valid;
            end
            if (adv_out) begin
                r_ov <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b1 <= i_in.data_byte;
        end
        if (adv_out && r_v1) begin
            r_ob <= n_ob;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_ob;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the printable rotation stream cipher. A scoreboard keeps its
// own keystream generator and rotation, predicts every result word from the
// accepted input words and compares the output stream in order. The run goes
// through directed corner words, then random bursts under several seed and
// direction settings, with random source gaps, sink stalls and one long sink
// hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module tb;

    import prsc_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 90;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_WORDS  = 180;
    localparam int DRAIN_CYCLES = 4;

    class cipher_scoreboard;
        logic [KS_W-1:0]   seed;
        logic              dir;
        logic [KS_W-1:0]   keystream;
        logic [BYTE_W-1:0] expected_bytes[$];
        int                mismatches;
        int                checked;

        function new();
            seed       = SEED_RESET;
            dir        = DIR_ENCRYPT;
            keystream  = SEED_RESET;
            mismatches = 0;
            checked    = 0;
        endfunction

        // value*75 mod 65537 by subtracting the high half of the product
        function logic [KS_W-1:0] lehmer_next(logic [KS_W-1:0] v);
            logic [PROD_W-1:0] p;
            int                d;
            p = PROD_W'(v) * PROD_W'(KS_MULT);
            d = int'(p[15:0]) - int'(p[PROD_W-1:16]);
            if (d < 0) begin
                d = d + int'(KS_MODULUS);
            end
            return d[KS_W-1:0];
        endfunction

        function logic [BYTE_W-1:0] rotate_printable(logic [BYTE_W-1:0] b,
                                                     logic [KS_W-1:0] ks, logic d);
            int span;
            int shift;
            int offs;
            if (b < PRINT_LO || b >= PRINT_HI) begin
                return b;
            end
            span  = int'(PRINT_SPAN);
            shift = int'(ks) % span;
            offs  = int'(b) - int'(PRINT_LO);
            if (d == DIR_DECRYPT) begin
                offs = (offs + span - shift) % span;
            end else begin
                offs = (offs + shift) % span;
            end
            return BYTE_W'(offs + int'(PRINT_LO));
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [KS_W-1:0] data);
            if (idx == REG_START_SEED) begin
                seed = data;
            end else if (idx == REG_DIRECTION) begin
                dir = data[0];
            end
        endfunction

        function void note_word(logic [BYTE_W-1:0] b, logic start);
            if (start) begin
                keystream = seed;
            end
            keystream = lehmer_next(keystream);
            expected_bytes.push_back(rotate_printable(b, keystream, dir));
        endfunction

        function void check_word(logic [BYTE_W-1:0] got);
            logic [BYTE_W-1:0] want;
            checked++;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: unexpected word out_byte=%0d", got);
                end
                return;
            end
            want = expected_bytes.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: word %0d out_byte expected %0d got %0d",
                             checked, want, got);
                end
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    prsc_in_if  in_ch ();
    prsc_out_if out_ch ();
    prsc_cfg_if cfg_ch ();

    printable_rotation_stream_cipher u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    cipher_scoreboard sb;
    int  cycle_count;
    int  words_in;
    int  restarts;
    int  in_stall_cycles;
    int  phases_run;
    bit  hold_off;

    initial begin
        i_clk = 1'b0;
    end

    always #(CLK_HALF) i_clk = ~i_clk;

    // bus monitor: everything is sampled at the rising edge
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.write_reg(cfg_ch.index, cfg_ch.data);
            end
            if (in_ch.valid && in_ch.ready) begin
                sb.note_word(in_ch.data_byte, in_ch.stream_start);
                words_in <= words_in + 1;
                if (in_ch.stream_start) begin
                    restarts <= restarts + 1;
                end
            end
            if (in_ch.valid && !in_ch.ready) begin
                in_stall_cycles <= in_stall_cycles + 1;
            end
            if (out_ch.valid && out_ch.ready) begin
                sb.check_word(out_ch.out_byte);
            end
        end
    end

    // sink stall pattern that switches between randomly chosen modes
    initial begin : sink_pattern
        int mode;
        int left;
        mode = 0;
        left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 300);
            end
            left--;
            if (hold_off) begin
                out_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= 1'($urandom_range(0, 1));
                    2:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // one long sink hold-off in the middle of the random traffic
    initial begin : long_hold
        hold_off = 1'b0;
        wait (words_in >= 500);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        if ($urandom_range(0, 3) != 0) begin
            return BYTE_W'($urandom_range(32, 127));
        end
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // caller is at a falling edge; returns at the falling edge after accept
    task automatic push_word(input logic [BYTE_W-1:0] b, input logic start);
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= b;
        in_ch.stream_start <= start;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // writes both registers back to back, valid held high between them
    task automatic configure(input logic [KS_W-1:0] seed, input logic dir);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_START_SEED;
        cfg_ch.data  <= seed;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.index <= REG_DIRECTION;
        cfg_ch.data  <= KS_W'(dir);
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        phases_run++;
    endtask

    task automatic send_random(input int count);
        int sent;
        int burst;
        int gap;
        int i;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 7) == 0) begin
                burst = $urandom_range(60, 200);
            end else begin
                burst = $urandom_range(1, 30);
            end
            for (i = 0; i < burst && sent < count; i++) begin
                push_word(rand_byte(), (sent == 0) || ($urandom_range(0, 19) == 0));
                sent++;
            end
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                in_ch.valid     <= 1'b0;
                in_ch.data_byte <= BYTE_W'($urandom_range(0, 255));
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    initial begin : main_seq
        logic [KS_W-1:0] seed;
        int              p;
        int              pick;
        sb              = new();
        cycle_count     = 0;
        words_in        = 0;
        restarts        = 0;
        in_stall_cycles = 0;
        phases_run      = 0;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.data_byte    <= '0;
        in_ch.stream_start <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= REG_START_SEED;
        cfg_ch.data        <= '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // no start yet: generator runs on from its reset value
        push_word(8'd0, 1'b0);
        push_word(8'd31, 1'b0);
        push_word(8'd32, 1'b0);
        push_word(8'd127, 1'b0);
        push_word(8'd128, 1'b0);
        push_word(8'd255, 1'b0);
        push_word(8'd65, 1'b0);
        push_word(8'd126, 1'b1);
        drain();

        // zero seed: generator sticks at zero, no rotation
        configure('0, DIR_ENCRYPT);
        push_word(8'd65, 1'b1);
        push_word(8'd127, 1'b0);
        push_word(8'd32, 1'b0);
        drain();

        configure(KS_W'(65536), DIR_DECRYPT);
        push_word(8'd32, 1'b1);
        push_word(8'd126, 1'b0);
        push_word(8'd122, 1'b0);
        push_word(8'd200, 1'b0);
        drain();

        // seeds above the modulus fold back into range on the first step
        configure('1, DIR_ENCRYPT);
        push_word(8'd77, 1'b1);
        push_word(8'd33, 1'b0);
        push_word(8'd127, 1'b0);
        drain();

        configure(KS_W'(65537), DIR_DECRYPT);
        push_word(8'd100, 1'b1);
        push_word(8'd50, 1'b0);
        drain();

        configure(SEED_RESET, DIR_DECRYPT);
        push_word(8'd64, 1'b1);
        push_word(8'd95, 1'b0);
        drain();

        for (p = 0; p < RAND_PHASES; p++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                seed = '0;
            end else if (pick == 1) begin
                seed = KS_W'(65536);
            end else if (pick == 2) begin
                seed = KS_W'($urandom_range(65537, 131071));
            end else begin
                seed = KS_W'($urandom_range(1, 65536));
            end
            configure(seed, (p % 2 == 0) ? DIR_ENCRYPT : DIR_DECRYPT);
            send_random(PHASE_WORDS);
            drain();
        end

        repeat (8) @(negedge i_clk);
        $display("covered %0d words over %0d register settings, %0d stream restarts",
                 words_in, phases_run, restarts);
        $display("input back-pressure seen on %0d cycles, %0d result words checked",
                 in_stall_cycles, sb.checked);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d words still expected", sb.mismatches,
                     sb.pending());
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/prsc_pkg.sv
rtl/core/prsc_in_if.sv
rtl/core/prsc_out_if.sv
rtl/core/prsc_cfg_if.sv
rtl/core/prsc_keygen.sv
rtl/core/prsc_rotate.sv
rtl/core/printable_rotation_stream_cipher.sv
test/tb.sv
